// File: sv/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

  // longest message the sequencer will follow, longer requests saturate
  localparam logic [15:0] MAX_MESSAGE_LENGTH = 16'd255;

  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_EVENT = 1'b1
  } func_t;

  // status word bit positions
  localparam int ST_SB   = 0;
  localparam int ST_ADDR = 1;
  localparam int ST_BTF  = 2;
  localparam int ST_TXE  = 3;
  localparam int ST_RXNE = 4;
  localparam int ST_BERR = 5;
  localparam int ST_ARLO = 6;
  localparam int ST_AF   = 7;

  // control set bits
  localparam logic [4:0] CS_PE    = 5'h01;
  localparam logic [4:0] CS_ACK   = 5'h02;
  localparam logic [4:0] CS_START = 5'h04;
  localparam logic [4:0] CS_STOP  = 5'h08;
  localparam logic [4:0] CS_POS   = 5'h10;

  // control clear bits
  localparam logic [3:0] CC_STOP = 4'h1;
  localparam logic [3:0] CC_ACK  = 4'h2;
  localparam logic [3:0] CC_BUF  = 4'h4;
  localparam logic [3:0] CC_ERR  = 4'h8;

  // status read requests
  localparam logic [1:0] RD_PAIR  = 2'h1;
  localparam logic [1:0] RD_DUMMY = 2'h2;

  typedef struct packed {
    logic       data_write_valid;
    logic [7:0] data_write_byte;
    logic       received_valid;
    logic [7:0] received_byte;
    logic [7:0] byte_index;
    logic [4:0] control_set;
    logic [3:0] control_clear;
    logic [1:0] status_reads;
    logic       done_res;
    logic [2:0] error_flags;
  } result_t;

endpackage

// File: sv/i2c_master_transfer_sequencer_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake          word
// in_       input      in_valid/in_stall  start item or status event
// out_      output     out_valid/out_stall one result per input word
//
// two register stages: input register, then the decision logic into the result
// register; a word enters every cycle while in_stall is low; out_valid rises when
// the word loads the result register, and message state is updated in that load,
// so back-to-back words see the state left by the word before them
// rst_n clears valids and message state; in_stall rises only while a result
// is held by out_stall and the input register is occupied

module i2c_master_transfer_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [6:0] in_target_address,
  input  logic       in_is_read,
  input  logic       in_send_stop,
  input  logic       in_restart,
  input  logic       in_first_message,
  input  logic [7:0] in_msg_length,
  input  logic [7:0] in_status,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_tx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_data_write_valid,
  output logic [7:0] out_data_write_byte,
  output logic       out_received_valid,
  output logic [7:0] out_received_byte,
  output logic [7:0] out_byte_index,
  output logic [4:0] out_control_set,
  output logic [3:0] out_control_clear,
  output logic [1:0] out_status_reads,
  output logic       out_done_res,
  output logic [2:0] out_error_flags
);

  // input register
  logic        in_valid_r;
  logic        func_r;
  logic [6:0]  target_r;
  logic        is_read_r;
  logic        send_stop_r;
  logic        restart_r;
  logic        first_r;
  logic [7:0]  length_r;
  logic [7:0]  status_r;
  logic [7:0]  rx_r;
  logic [7:0]  tx_r;

  // message state
  logic [6:0]  saved_target_r, saved_target_nxt;
  logic        read_mode_r, read_mode_nxt;
  logic        stop_wanted_r, stop_wanted_nxt;
  logic [7:0]  msg_len_r, msg_len_nxt;
  logic [7:0]  byte_pos_r, byte_pos_nxt;
  logic [2:0]  err_acc_r, err_acc_nxt;

  // result register
  logic                 out_valid_r;
  i2cms_pkg::result_t   res_r, res_nxt;

  logic        advance;
  logic [7:0]  start_len;
  logic [7:0]  pos_inc;
  logic [7:0]  left;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      func_r      <= in_func;
      target_r    <= in_target_address;
      is_read_r   <= in_is_read;
      send_stop_r <= in_send_stop;
      restart_r   <= in_restart;
      first_r     <= in_first_message;
      length_r    <= in_msg_length;
      status_r    <= in_status;
      rx_r        <= in_rx_byte;
      tx_r        <= in_tx_byte;
    end
  end

  // saturate the requested length
  assign start_len = ({8'd0, length_r} > i2cms_pkg::MAX_MESSAGE_LENGTH) ?
                     i2cms_pkg::MAX_MESSAGE_LENGTH[7:0] : length_r;
  assign pos_inc   = byte_pos_r + 8'd1;
  assign left      = msg_len_r - byte_pos_r;

  always_comb begin
    saved_target_nxt = saved_target_r;
    read_mode_nxt    = read_mode_r;
    stop_wanted_nxt  = stop_wanted_r;
    msg_len_nxt      = msg_len_r;
    byte_pos_nxt     = byte_pos_r;
    err_acc_nxt      = err_acc_r;
    res_nxt          = '0;

    unique case (i2cms_pkg::func_t'(func_r))
      i2cms_pkg::FUNC_START: begin
        saved_target_nxt    = target_r;
        read_mode_nxt       = is_read_r;
        stop_wanted_nxt     = send_stop_r;
        msg_len_nxt         = start_len;
        byte_pos_nxt        = 8'd0;
        err_acc_nxt         = 3'd0;
        res_nxt.control_set = i2cms_pkg::CS_PE | i2cms_pkg::CS_ACK;
        if (first_r || restart_r) begin
          res_nxt.control_clear = i2cms_pkg::CC_STOP;
          res_nxt.control_set   = res_nxt.control_set | i2cms_pkg::CS_START;
        end
      end
      i2cms_pkg::FUNC_EVENT: begin
        // error flags first, then at most one event
        if (status_r[7:5] != 3'd0) begin
          if (status_r[i2cms_pkg::ST_AF]) begin
            res_nxt.control_set = i2cms_pkg::CS_STOP;
          end
          err_acc_nxt           = err_acc_r | status_r[7:5];
          res_nxt.control_clear = i2cms_pkg::CC_ERR;
          res_nxt.done_res      = 1'b1;
        end

        priority if (status_r[i2cms_pkg::ST_SB]) begin
          res_nxt.data_write_valid = 1'b1;
          res_nxt.data_write_byte  = {saved_target_r, read_mode_r};
          if (read_mode_r && msg_len_r == 8'd2) begin
            res_nxt.control_set = res_nxt.control_set | i2cms_pkg::CS_POS;
          end
        end else if (status_r[i2cms_pkg::ST_ADDR]) begin
          if (read_mode_r && msg_len_r <= 8'd2) begin
            res_nxt.control_clear = res_nxt.control_clear | i2cms_pkg::CC_ACK;
            if (msg_len_r == 8'd2) begin
              res_nxt.control_set = res_nxt.control_set | i2cms_pkg::CS_POS;
            end
          end
          res_nxt.status_reads = i2cms_pkg::RD_PAIR;
        end else if ((status_r[i2cms_pkg::ST_TXE] || status_r[i2cms_pkg::ST_BTF])
                     && !read_mode_r) begin
          if (byte_pos_r < msg_len_r) begin
            res_nxt.data_write_valid = 1'b1;
            res_nxt.data_write_byte  = tx_r;
            res_nxt.byte_index       = byte_pos_r;
            byte_pos_nxt             = pos_inc;
            if (pos_inc == msg_len_r) begin
              res_nxt.control_clear = res_nxt.control_clear | i2cms_pkg::CC_BUF;
            end
          end else begin
            if (stop_wanted_r) begin
              res_nxt.control_set = res_nxt.control_set | i2cms_pkg::CS_STOP;
            end
            if (status_r[i2cms_pkg::ST_BTF]) begin
              res_nxt.status_reads = i2cms_pkg::RD_DUMMY;
            end
            res_nxt.done_res = 1'b1;
          end
        end else if ((status_r[i2cms_pkg::ST_RXNE] || status_r[i2cms_pkg::ST_BTF])
                     && read_mode_r) begin
          if (byte_pos_r < msg_len_r) begin
            if (left == 8'd1) begin
              if (stop_wanted_r) begin
                res_nxt.control_set = res_nxt.control_set | i2cms_pkg::CS_STOP;
              end
              res_nxt.control_clear = res_nxt.control_clear | i2cms_pkg::CC_BUF;
              res_nxt.done_res      = 1'b1;
            end else if (left == 8'd2) begin
              res_nxt.control_clear = res_nxt.control_clear | i2cms_pkg::CC_ACK;
              res_nxt.control_set   = res_nxt.control_set | i2cms_pkg::CS_POS;
            end
            res_nxt.received_valid = 1'b1;
            res_nxt.received_byte  = rx_r;
            res_nxt.byte_index     = byte_pos_r;
            byte_pos_nxt           = pos_inc;
          end else begin
            if (stop_wanted_r) begin
              res_nxt.control_set = res_nxt.control_set | i2cms_pkg::CS_STOP;
            end
            res_nxt.done_res = 1'b1;
          end
        end else begin
          res_nxt.status_reads = res_nxt.status_reads;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase

    res_nxt.error_flags = err_acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      saved_target_r <= '0;
      read_mode_r    <= 1'b0;
      stop_wanted_r  <= 1'b0;
      msg_len_r      <= '0;
      byte_pos_r     <= '0;
      err_acc_r      <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        saved_target_r <= saved_target_nxt;
        read_mode_r    <= read_mode_nxt;
        stop_wanted_r  <= stop_wanted_nxt;
        msg_len_r      <= msg_len_nxt;
        byte_pos_r     <= byte_pos_nxt;
        err_acc_r      <= err_acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data_write_valid = res_r.data_write_valid;
  assign out_data_write_byte  = res_r.data_write_byte;
  assign out_received_valid   = res_r.received_valid;
  assign out_received_byte    = res_r.received_byte;
  assign out_byte_index       = res_r.byte_index;
  assign out_control_set      = res_r.control_set;
  assign out_control_clear    = res_r.control_clear;
  assign out_status_reads     = res_r.status_reads;
  assign out_done_res         = res_r.done_res;
  assign out_error_flags      = res_r.error_flags;

`ifndef SYNTHESIS
  // the position never runs past the message length
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= msg_len_r)
    else $error("byte position beyond message length");

  // a result never both writes and stores a byte
  a_one_data_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.data_write_valid && res_r.received_valid))
    else $error("write and receive in one result");

  // the input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && in_valid_r))
    else $error("input stalled without a held result");

  // a stored byte always advances the position by one
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && res_nxt.received_valid) |=> byte_pos_r == $past(pos_inc))
    else $error("position did not advance after receive");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    i2cms_pkg::func_t func;
    logic [6:0]       target_address;
    logic             is_read;
    logic             send_stop;
    logic             restart;
    logic             first_message;
    logic [7:0]       msg_length;
    logic [7:0]       status;
    logic [7:0]       rx_byte;
    logic [7:0]       tx_byte;
  } seq_word_t;

  localparam logic [7:0] S_SB   = 8'(1 << i2cms_pkg::ST_SB);
  localparam logic [7:0] S_ADDR = 8'(1 << i2cms_pkg::ST_ADDR);
  localparam logic [7:0] S_BTF  = 8'(1 << i2cms_pkg::ST_BTF);
  localparam logic [7:0] S_TXE  = 8'(1 << i2cms_pkg::ST_TXE);
  localparam logic [7:0] S_RXNE = 8'(1 << i2cms_pkg::ST_RXNE);
  localparam logic [7:0] S_BERR = 8'(1 << i2cms_pkg::ST_BERR);
  localparam logic [7:0] S_ARLO = 8'(1 << i2cms_pkg::ST_ARLO);
  localparam logic [7:0] S_AF   = 8'(1 << i2cms_pkg::ST_AF);

  localparam int RANDOM_WORDS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_func = 1'b0;
  logic [6:0] in_target_address = '0;
  logic       in_is_read = 1'b0;
  logic       in_send_stop = 1'b0;
  logic       in_restart = 1'b0;
  logic       in_first_message = 1'b0;
  logic [7:0] in_msg_length = '0;
  logic [7:0] in_status = '0;
  logic [7:0] in_rx_byte = '0;
  logic [7:0] in_tx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_data_write_valid;
  logic [7:0] out_data_write_byte;
  logic       out_received_valid;
  logic [7:0] out_received_byte;
  logic [7:0] out_byte_index;
  logic [4:0] out_control_set;
  logic [3:0] out_control_clear;
  logic [1:0] out_status_reads;
  logic       out_done_res;
  logic [2:0] out_error_flags;

  i2c_master_transfer_sequencer_top dut (.*);

  seq_word_t          pending_words[$];
  i2cms_pkg::result_t expected_results[$];
  seq_word_t          cur_word;
  int        total_words = 1;
  int        accepted_count = 0;
  int        stim_phase = 0;
  int        mismatch_count = 0;
  int        hold_left = 0;
  bit        pressure_done = 1'b0;

  // message state of the sequencer as predicted
  logic [6:0] msg_target = '0;
  logic       msg_read = 1'b0;
  logic       msg_stop = 1'b0;
  logic [7:0] msg_len = '0;
  logic [7:0] msg_pos = '0;
  logic [2:0] msg_errors = '0;

  function automatic i2cms_pkg::result_t sequencer_step(input seq_word_t w);
    i2cms_pkg::result_t r;
    logic [7:0]         st;
    logic [7:0]         left;
    r = '0;
    st = w.status;
    if (w.func == i2cms_pkg::FUNC_START) begin
      msg_target = w.target_address;
      msg_read   = w.is_read;
      msg_stop   = w.send_stop;
      msg_len    = (16'(w.msg_length) > i2cms_pkg::MAX_MESSAGE_LENGTH) ?
                   i2cms_pkg::MAX_MESSAGE_LENGTH[7:0] : w.msg_length;
      msg_pos    = '0;
      msg_errors = '0;
      r.control_set = i2cms_pkg::CS_PE | i2cms_pkg::CS_ACK;
      if (w.first_message || w.restart) begin
        r.control_clear |= i2cms_pkg::CC_STOP;
        r.control_set   |= i2cms_pkg::CS_START;
      end
    end else begin
      if (st[i2cms_pkg::ST_AF:i2cms_pkg::ST_BERR] != 3'b000) begin
        if (st[i2cms_pkg::ST_AF]) r.control_set |= i2cms_pkg::CS_STOP;
        msg_errors = msg_errors | st[i2cms_pkg::ST_AF:i2cms_pkg::ST_BERR];
        r.control_clear |= i2cms_pkg::CC_ERR;
        r.done_res = 1'b1;
      end
      if (st[i2cms_pkg::ST_SB]) begin
        r.data_write_valid = 1'b1;
        r.data_write_byte  = {msg_target, msg_read};
        if (msg_read && msg_len == 8'd2) r.control_set |= i2cms_pkg::CS_POS;
      end else if (st[i2cms_pkg::ST_ADDR]) begin
        if (msg_read && msg_len <= 8'd2) begin
          r.control_clear |= i2cms_pkg::CC_ACK;
          if (msg_len == 8'd2) r.control_set |= i2cms_pkg::CS_POS;
        end
        r.status_reads |= i2cms_pkg::RD_PAIR;
      end else if ((st[i2cms_pkg::ST_TXE] || st[i2cms_pkg::ST_BTF]) && !msg_read) begin
        if (msg_pos < msg_len) begin
          r.data_write_valid = 1'b1;
          r.data_write_byte  = w.tx_byte;
          r.byte_index       = msg_pos;
          msg_pos = msg_pos + 8'd1;
          if (msg_pos == msg_len) r.control_clear |= i2cms_pkg::CC_BUF;
        end else begin
          if (msg_stop) r.control_set |= i2cms_pkg::CS_STOP;
          if (st[i2cms_pkg::ST_BTF]) r.status_reads |= i2cms_pkg::RD_DUMMY;
          r.done_res = 1'b1;
        end
      end else if ((st[i2cms_pkg::ST_RXNE] || st[i2cms_pkg::ST_BTF]) && msg_read) begin
        if (msg_pos < msg_len) begin
          left = msg_len - msg_pos;
          // last byte: stop if wanted, and done; next to last: nack with pos
          if (left == 8'd1) begin
            if (msg_stop) r.control_set |= i2cms_pkg::CS_STOP;
            r.control_clear |= i2cms_pkg::CC_BUF;
            r.done_res = 1'b1;
          end else if (left == 8'd2) begin
            r.control_clear |= i2cms_pkg::CC_ACK;
            r.control_set   |= i2cms_pkg::CS_POS;
          end
          r.received_valid = 1'b1;
          r.received_byte  = w.rx_byte;
          r.byte_index     = msg_pos;
          msg_pos = msg_pos + 8'd1;
        end else begin
          if (msg_stop) r.control_set |= i2cms_pkg::CS_STOP;
          r.done_res = 1'b1;
        end
      end
    end
    r.error_flags = msg_errors;
    return r;
  endfunction

  function automatic string fmt_result(input i2cms_pkg::result_t r);
    return $sformatf({"wr=%0d/%02h rx=%0d/%02h idx=%0d set=%02h clr=%01h",
                      " rd=%0d done=%0d err=%0d"},
                     r.data_write_valid, r.data_write_byte, r.received_valid,
                     r.received_byte, r.byte_index, r.control_set, r.control_clear,
                     r.status_reads, r.done_res, r.error_flags);
  endfunction

  function automatic seq_word_t rand_word();
    seq_word_t w;
    w.func           = i2cms_pkg::func_t'($urandom_range(0, 1));
    w.target_address = 7'($urandom_range(0, 127));
    w.is_read        = 1'($urandom_range(0, 1));
    w.send_stop      = 1'($urandom_range(0, 1));
    w.restart        = 1'($urandom_range(0, 1));
    w.first_message  = 1'($urandom_range(0, 1));
    w.msg_length     = 8'($urandom_range(0, 255));
    w.status         = 8'($urandom_range(0, 255));
    w.rx_byte        = 8'($urandom_range(0, 255));
    w.tx_byte        = 8'($urandom_range(0, 255));
    return w;
  endfunction

  function automatic seq_word_t start_word(input logic [6:0] tgt, input logic rd,
                                           input logic stp, input logic rs,
                                           input logic fm, input logic [7:0] len);
    seq_word_t w;
    w = rand_word();
    w.func = i2cms_pkg::FUNC_START;
    w.target_address = tgt;
    w.is_read = rd;
    w.send_stop = stp;
    w.restart = rs;
    w.first_message = fm;
    w.msg_length = len;
    return w;
  endfunction

  function automatic seq_word_t event_word(input logic [7:0] st);
    seq_word_t w;
    w = rand_word();
    w.func = i2cms_pkg::FUNC_EVENT;
    w.status = st;
    return w;
  endfunction

  // occasional error flags riding on an otherwise clean event
  function automatic logic [7:0] maybe_error();
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(1, 7) << i2cms_pkg::ST_BERR);
    return 8'h00;
  endfunction

  task automatic add_message(input int len, input bit cut);
    seq_word_t   s;
    int          n_data;
    logic [7:0]  st;
    s = rand_word();
    s.func = i2cms_pkg::FUNC_START;
    s.msg_length = len[7:0];
    pending_words.push_back(s);
    pending_words.push_back(event_word(S_SB | maybe_error()));
    pending_words.push_back(event_word(S_ADDR | maybe_error()));
    n_data = cut ? $urandom_range(0, len) : len + 1;
    for (int i = 0; i < n_data; i++) begin
      case ($urandom_range(0, 2))
        0: st = s.is_read ? S_RXNE : S_TXE;
        1: st = S_BTF;
        default: st = (s.is_read ? S_RXNE : S_TXE) | S_BTF;
      endcase
      pending_words.push_back(event_word(st | maybe_error()));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: one word on the bus, held while stalled
  always @(posedge clk) begin : drive_words
    int idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(sequencer_step(cur_word));
        accepted_count++;
      end
      stim_phase <= (accepted_count * 3 / total_words > 2) ? 2
                                                           : accepted_count * 3 / total_words;
      case (stim_phase)
        0: idle_pct = 13;
        1: idle_pct = 81;
        default: idle_pct = 0;
      endcase
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_word = pending_words.pop_front();
          in_func           <= cur_word.func;
          in_target_address <= cur_word.target_address;
          in_is_read        <= cur_word.is_read;
          in_send_stop      <= cur_word.send_stop;
          in_restart        <= cur_word.restart;
          in_first_message  <= cur_word.first_message;
          in_msg_length     <= cur_word.msg_length;
          in_status         <= cur_word.status;
          in_rx_byte        <= cur_word.rx_byte;
          in_tx_byte        <= cur_word.tx_byte;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, plus one long hold-off when the last phase begins
  always @(posedge clk) begin : drive_stall
    int idle_pct;
    case (stim_phase)
      0: idle_pct = 81;
      1: idle_pct = 13;
      default: idle_pct = 0;
    endcase
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stim_phase == 2 && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    i2cms_pkg::result_t got;
    i2cms_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_data_write_valid, out_data_write_byte, out_received_valid,
             out_received_byte, out_byte_index, out_control_set, out_control_clear,
             out_status_reads, out_done_res, out_error_flags};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word: %s", fmt_result(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %s", fmt_result(want));
            $display("          actual   %s", fmt_result(got));
          end
        end
      end
    end
  end

  initial begin
    seq_word_t w;
    int n_directed;
    // event before any start item: write with zero length completes at once
    pending_words.push_back(event_word(S_TXE));
    pending_words.push_back(event_word(8'hFF));
    // two-byte read with stop
    pending_words.push_back(start_word(7'h7F, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2));
    pending_words.push_back(event_word(S_SB));
    pending_words.push_back(event_word(S_ADDR));
    pending_words.push_back(event_word(S_RXNE));
    pending_words.push_back(event_word(S_RXNE));
    pending_words.push_back(event_word(S_BTF));
    // one-byte write on a repeated start, no stop
    pending_words.push_back(start_word(7'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'd1));
    pending_words.push_back(event_word(S_SB));
    pending_words.push_back(event_word(S_ADDR));
    pending_words.push_back(event_word(S_TXE));
    pending_words.push_back(event_word(S_BTF));
    // one-byte read without start condition
    pending_words.push_back(start_word(7'h55, 1'b1, 1'b1, 1'b0, 1'b0, 8'd1));
    pending_words.push_back(event_word(S_SB));
    pending_words.push_back(event_word(S_ADDR));
    pending_words.push_back(event_word(S_RXNE));
    // errors mixed with event bits, then errors alone
    pending_words.push_back(event_word(S_AF | S_TXE));
    pending_words.push_back(event_word(S_BERR | S_ARLO));
    // longest message
    pending_words.push_back(start_word(7'h2A, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF));
    w = event_word(S_TXE);
    w.tx_byte = 8'hFF;
    pending_words.push_back(w);
    w = event_word(S_TXE | S_BTF);
    w.rx_byte = 8'hFF;
    w.tx_byte = 8'h00;
    pending_words.push_back(w);
    // zero-length read, surplus receive, empty status
    pending_words.push_back(start_word(7'h01, 1'b1, 1'b0, 1'b0, 1'b0, 8'd0));
    pending_words.push_back(event_word(S_RXNE));
    pending_words.push_back(event_word(8'h00));
    n_directed = pending_words.size();

    add_message($urandom_range(250, 255), 1'b0);
    while (pending_words.size() < n_directed + RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 12)
        pending_words.push_back(rand_word());
      else if ($urandom_range(0, 11) == 0)
        add_message($urandom_range(16, 64), $urandom_range(0, 9) == 0);
      else
        add_message($urandom_range(0, 5), $urandom_range(0, 9) == 0);
    end
    total_words = pending_words.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
sv/i2cms_pkg.sv
sv/i2c_master_transfer_sequencer_top.sv
dv/testbench.sv
